// File: sv/pzrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzrd_pkg: shared types and constants of the zero-run pixel decoder
// Word formats, configuration register codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pzrd_pkg;

  // Symbol plus count field width, default for the top level parameter
  localparam int unsigned SymbolPlusCountBits = 16;

  // Fixed field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PixelW    = 8;
  localparam int unsigned CountW    = 32;
  localparam int unsigned BppW      = 4;
  localparam int unsigned DimW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PixelW-1:0] PixelMask  = 8'hFF;
  localparam logic [BppW-1:0]   BppReset   = 4'd8;
  localparam logic [BppW-1:0]   BppMin     = 4'd1;
  localparam logic [BppW-1:0]   BppMax     = 4'd8;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // Input word
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             final_byte;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [PixelW-1:0] pixel_value;
    logic [CountW-1:0] repeat_count;
    logic              image_done;
    logic              clipped;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TAIL,
    ST_FILL
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // append the accepted byte to the bit buffer
    logic step;   // take one symbol or count field
    logic tail;   // take the zero-padded remainder after the final byte
    logic fill;   // emit the closing zero run and clear image state
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_bits;  // enough buffered bits for the next field
    logic out_free;   // output register can take a word this cycle
    logic last;       // the byte being decoded was marked final
  } dp_status_t;

endpackage

// File: sv/pzrd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzrd_datapath: bit buffer, run emission and output register
// Holds the configuration registers, the LSB-first bit buffer, the
// symbol/count mode, the pixel counter and the registered output word.
// ----------------------------------------------------------------------------
module pzrd_datapath #(
  parameter int unsigned SYMBOL_PLUS_COUNT_BITS = pzrd_pkg::SymbolPlusCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pzrd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pzrd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  pzrd_pkg::in_word_t             in_data_i,
  input  pzrd_pkg::dp_cmd_t              cmd_i,
  output pzrd_pkg::dp_status_t           status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output pzrd_pkg::out_word_t            out_data_o
);
  import pzrd_pkg::*;

  // Buffer holds at most one short field plus one byte
  localparam int unsigned BufW  = SYMBOL_PLUS_COUNT_BITS + 6;
  localparam int unsigned FillW = $clog2(BufW + 1);
  localparam int unsigned TakeW = SYMBOL_PLUS_COUNT_BITS - 1;
  localparam int unsigned NeedW = $clog2(SYMBOL_PLUS_COUNT_BITS);

  logic [BppW-1:0]   bpp_q;
  logic [DimW-1:0]   width_q, height_q;
  logic [CountW-1:0] total_q;
  logic [BufW-1:0]   buf_q;
  logic [FillW-1:0]  fill_q;
  logic              rrc_q;
  logic              last_q;
  logic [CountW-1:0] pixels_q;
  logic              out_valid_q;
  out_word_t         out_q;

  logic [BppW-1:0]   sym_w;
  logic [NeedW-1:0]  need;
  logic [TakeW-1:0]  take_mask;
  logic [TakeW-1:0]  take_val;
  logic [CountW-1:0] remaining;
  logic              room;
  logic              emit_req, emit_ok, clip;
  logic [PixelW-1:0] emit_val;
  logic [CountW-1:0] emit_cnt, run_cnt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BppReset;
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BPP:    bpp_q    <= cfg_data_i[BppW-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Register the image pixel count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= CountW'(width_q) * CountW'(height_q);
    end
  end

  // Clamp symbol width and pick the field length
  always_comb begin
    if (bpp_q < BppMin) begin
      sym_w = BppMin;
    end else if (bpp_q > BppMax) begin
      sym_w = BppMax;
    end else begin
      sym_w = bpp_q;
    end
    need = rrc_q ? (NeedW'(SYMBOL_PLUS_COUNT_BITS) - NeedW'(sym_w)) : NeedW'(sym_w);
  end

  // Extract the next field; on tail the buffer holds only valid bits
  always_comb begin
    for (int i = 0; i < TakeW; i++) begin
      take_mask[i] = (NeedW'(i) < need);
    end
    take_val = cmd_i.tail ? buf_q[TakeW-1:0] : (buf_q[TakeW-1:0] & take_mask);
  end

  // Select the run to emit
  always_comb begin
    emit_req = 1'b0;
    emit_val = '0;
    emit_cnt = '0;
    if (cmd_i.step || cmd_i.tail) begin
      if (rrc_q) begin
        emit_req = 1'b1;
        emit_cnt = CountW'(take_val);
      end else if (take_val != '0) begin
        emit_req = 1'b1;
        emit_val = take_val[PixelW-1:0] & PixelMask;
        emit_cnt = CountW'(1);
      end
    end else if (cmd_i.fill) begin
      emit_req = 1'b1;
      emit_cnt = remaining;
    end
  end

  // Clip the run against the pixels left in the image
  assign remaining = total_q - pixels_q;
  assign room      = (pixels_q < total_q);
  assign emit_ok   = emit_req && (emit_cnt != '0) && room;
  assign clip      = (emit_cnt > remaining);
  assign run_cnt   = clip ? remaining : emit_cnt;

  // Bit buffer, mode and pixel count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      fill_q   <= '0;
      rrc_q    <= 1'b0;
      last_q   <= 1'b0;
      pixels_q <= '0;
    end else begin
      if (cmd_i.load) begin
        buf_q  <= buf_q | (BufW'(in_data_i.data_byte) << fill_q);
        fill_q <= fill_q + FillW'(ByteW);
        last_q <= in_data_i.final_byte;
      end else if (cmd_i.step) begin
        buf_q  <= buf_q >> need;
        fill_q <= fill_q - FillW'(need);
        rrc_q  <= rrc_q ? 1'b0 : (take_val == '0);
      end else if (cmd_i.tail || cmd_i.fill) begin
        buf_q  <= '0;
        fill_q <= '0;
        rrc_q  <= 1'b0;
      end
      if (cmd_i.fill) begin
        pixels_q <= '0;
      end else if (emit_ok) begin
        pixels_q <= pixels_q + run_cnt;
      end
    end
  end

  // Output register: load on emission, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      out_q.pixel_value  <= emit_val;
      out_q.repeat_count <= run_cnt;
      out_q.image_done   <= (run_cnt == remaining);
      out_q.clipped      <= clip;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.have_bits = (fill_q >= FillW'(need));
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.last      = last_q;

endmodule

// File: sv/pzrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzrd_ctrl: decode sequencer
// Accepts a byte, steps the buffered fields one per cycle while output is
// free, and after the final byte runs the padded tail and the closing fill.
// ----------------------------------------------------------------------------
module pzrd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pzrd_pkg::dp_status_t  status_i,
  output pzrd_pkg::dp_cmd_t     cmd_o
);
  import pzrd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status_i.have_bits) state_d = status_i.last ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        if (status_i.out_free) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands; hold every step, tail and fill until the output slot is free
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: cmd_o.step = status_i.have_bits && status_i.out_free;
      ST_TAIL:   cmd_o.tail = status_i.out_free;
      ST_FILL:   cmd_o.fill = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/packed_zero_run_pixel_decoder_top.sv
// A byte enters the bit buffer at its accepting edge; the first decode step
// that emits loads its first run into the output register.
// A new byte is taken only in idle, after every symbol or count field that the
// last byte completed has been stepped; a final byte adds the padded tail and
// the fill run; output stalls hold the steps, the tail and the fill.
// Reset: asynchronous, active low; clears decode state, sets width 8, size 0.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_zero_run_pixel_decoder_top: zero-run pixel stream decoder
// Reads packed symbols LSB first from a byte stream and emits value/count
// runs clipped to the configured image size.
// ----------------------------------------------------------------------------
module packed_zero_run_pixel_decoder_top #(
  parameter int unsigned SYMBOL_PLUS_COUNT_BITS = pzrd_pkg::SymbolPlusCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pzrd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pzrd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pzrd_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pzrd_pkg::out_word_t            out_data_o
);
  import pzrd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  pzrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pzrd_datapath #(
    .SYMBOL_PLUS_COUNT_BITS (SYMBOL_PLUS_COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/pzrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzrd_checker: port-level checks of the zero-run pixel decoder
// Watches the top level ports and flags run words or handshakes that the
// decoder must never produce.
// ----------------------------------------------------------------------------
module pzrd_port_checks (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pzrd_pkg::out_word_t  out_data_o
);
  import pzrd_pkg::*;

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // Never emit an empty run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.repeat_count != '0)
    else $error("run with zero repeat count");

  // A clipped run always ends the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |-> out_data_o.image_done)
    else $error("clipped run without image_done");

  // Drop ready while a byte is being decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a byte");

endmodule

bind packed_zero_run_pixel_decoder_top pzrd_port_checks u_pzrd_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: test/pzrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzrd_checker: run predictor and comparator for the zero-run pixel decoder
// Watches the register, byte and run channels. Keeps its own copy of the
// registers and the decode state, queues the runs that each accepted byte
// must produce, and compares each accepted run with the oldest queued one.
// ----------------------------------------------------------------------------
module pzrd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pzrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pzrd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  pzrd_pkg::in_word_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  pzrd_pkg::out_word_t           out_data_i,
  output int                            fail_count_o,
  output int                            runs_pending_o,
  output int                            runs_checked_o,
  output int                            clipped_runs_o
);
  import pzrd_pkg::*;

  // Register copies
  logic [BppW-1:0] bpp_reg;
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;

  // Decode state
  logic [31:0]     bit_acc;
  int unsigned     acc_bits;
  logic            count_next;
  logic [31:0]     px_done;

  out_word_t       runs_due[$];
  int              mismatches = 0;
  int              pending_runs = 0;
  int              runs_checked = 0;
  int              clipped_runs = 0;

  assign fail_count_o   = mismatches;
  assign runs_pending_o = pending_runs;
  assign runs_checked_o = runs_checked;
  assign clipped_runs_o = clipped_runs;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t ns: run mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Clamp the symbol width to 1..8
  function automatic int unsigned symbol_width();
    if (bpp_reg == '0) return BppMin;
    if (bpp_reg > BppMax) return BppMax;
    return bpp_reg;
  endfunction

  // Take the k oldest bits of the accumulator
  function automatic logic [31:0] pull_bits(int unsigned k);
    logic [31:0] v;
    v = bit_acc & ((32'd1 << k) - 32'd1);
    bit_acc = bit_acc >> k;
    acc_bits = acc_bits - k;
    return v;
  endfunction

  // Clip a run to the image and queue it
  task automatic queue_run(logic [PixelW-1:0] value, logic [31:0] count);
    logic [63:0] total;
    logic [63:0] left;
    out_word_t   r;
    total = 64'(width_reg) * 64'(height_reg);
    if (count == '0) return;
    if (64'(px_done) >= total) return;
    left = total - 64'(px_done);
    r.clipped = 1'b0;
    if (64'(count) > left) begin
      count = left[31:0];
      r.clipped = 1'b1;
    end
    px_done = px_done + count;
    r.pixel_value  = value & PixelMask;
    r.repeat_count = count;
    r.image_done   = (64'(px_done) == total);
    runs_due.push_back(r);
  endtask

  // Append one byte and decode every symbol and count it completes
  task automatic decode_byte(in_word_t w);
    int unsigned need;
    logic [31:0] v;
    logic [63:0] total;
    bit          starved;
    bit_acc  = bit_acc | (32'(w.data_byte) << acc_bits);
    acc_bits = acc_bits + ByteW;
    starved  = 1'b0;
    while (!starved) begin
      need = count_next ? SymbolPlusCountBits - symbol_width() : symbol_width();
      if (acc_bits < need) begin
        starved = 1'b1;
      end else begin
        v = pull_bits(need);
        if (count_next) begin
          queue_run('0, v);
          count_next = 1'b0;
        end else if (v != '0) begin
          queue_run(v[PixelW-1:0], 32'd1);
        end else begin
          count_next = 1'b1;
        end
      end
    end
    if (w.final_byte) begin
      // pad the remainder with zeros, then fill the rest of the image
      v = pull_bits(acc_bits);
      if (count_next) queue_run('0, v);
      else if (v != '0) queue_run(v[PixelW-1:0], 32'd1);
      total = 64'(width_reg) * 64'(height_reg);
      if (64'(px_done) < total) queue_run('0, 32'(total - 64'(px_done)));
      bit_acc    = '0;
      acc_bits   = 0;
      count_next = 1'b0;
      px_done    = '0;
    end
  endtask

  // Compare one accepted run with the oldest queued one
  task automatic check_run(out_word_t got);
    out_word_t want;
    if (runs_due.size() == 0) begin
      report_mismatch("run with nothing queued", got, '0);
      return;
    end
    want = runs_due.pop_front();
    runs_checked++;
    if (want.clipped) clipped_runs++;
    if (got.pixel_value !== want.pixel_value)
      report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
    if (got.repeat_count !== want.repeat_count)
      report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
    if (got.image_done !== want.image_done)
      report_mismatch("image_done", got.image_done, want.image_done);
    if (got.clipped !== want.clipped)
      report_mismatch("clipped", got.clipped, want.clipped);
  endtask

  // Track the channels; check runs before predicting from a new byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_reg    = BppReset;
      width_reg  = '0;
      height_reg = '0;
      bit_acc    = '0;
      acc_bits   = 0;
      count_next = 1'b0;
      px_done    = '0;
      runs_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_run(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BPP:    bpp_reg    = cfg_data_i[BppW-1:0];
          CFG_WIDTH:  width_reg  = cfg_data_i;
          CFG_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
    end
    pending_runs = runs_due.size();
  end

endmodule

// File: test/packed_zero_run_pixel_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_zero_run_pixel_decoder_top_tb: testbench of the zero-run decoder
// Drives directed and random compressed images through the byte channel
// under three pacing modes, rewrites symbol width and image size between
// words while the block is idle, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module packed_zero_run_pixel_decoder_top_tb;
  import pzrd_pkg::*;

  localparam int DrainCycles   = 16;
  localparam int QuietLimit    = 2000;
  localparam int PhaseBytes    = 92;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CFG_BPP;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;

  int fail_count;
  int runs_pending;
  int runs_checked;
  int clipped_runs;
  int tx_idle_pct = 21;
  int rx_idle_pct = 77;
  int bytes_sent = 0;
  int phase_bytes = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  packed_zero_run_pixel_decoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  pzrd_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_word),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_word),
    .fail_count_o   (fail_count),
    .runs_pending_o (runs_pending),
    .runs_checked_o (runs_checked),
    .clipped_runs_o (clipped_runs)
  );

  // Stall the run channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("packed_zero_run_pixel_decoder_top_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one byte word, with random gaps ahead of it
  task automatic push_word(logic [ByteW-1:0] data, logic fin);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_word.data_byte  <= data;
    in_word.final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    phase_bytes++;
  endtask

  // Drop valid and wait until every queued run is out and the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (runs_pending != 0 || !in_ready) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_image(logic [CfgDataW-1:0] bpp, logic [DimW-1:0] w, logic [DimW-1:0] h);
    write_reg(CFG_BPP, bpp);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // Mostly legal widths, some out of range, some with junk in the upper bits
  function automatic logic [CfgDataW-1:0] random_bpp_word();
    logic [BppW-1:0]          b;
    logic [CfgDataW-BppW-1:0] junk;
    case ($urandom_range(9))
      0:       b = '0;
      1:       b = BppW'($urandom_range(15, 9));
      default: b = BppW'($urandom_range(8, 1));
    endcase
    junk = (CfgDataW-BppW)'($urandom);
    if ($urandom_range(7) != 0) junk = '0;
    return {junk, b};
  endfunction

  function automatic logic [DimW-1:0] random_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return DimW'($urandom_range(12, 1));
    endcase
  endfunction

  // Bias toward zero bits so zero symbols and short counts show up often
  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    a = ByteW'($urandom);
    b = ByteW'($urandom);
    case ($urandom_range(3))
      0:       return '0;
      1:       return a;
      2:       return a & b;
      default: return a | b;
    endcase
  endfunction

  // One random image, sometimes with a new width partway through
  task automatic random_image();
    int n;
    n = $urandom_range(12, 1);
    if ($urandom_range(1) == 0) begin
      settle();
      set_image(random_bpp_word(), random_dim(), random_dim());
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(19) == 0) begin
        settle();
        write_reg(CFG_BPP, random_bpp_word());
      end
      push_word(pick_byte(), i == n - 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // image size is zero out of reset: nothing comes out
    push_word(8'hFF, 1'b1);

    // pixels, a zero count, a zero run, padded zero symbol, closing fill
    settle();
    set_image(16'd8, 16'd4, 16'd2);
    push_word(8'hFF, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h02, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h00, 1'b1);

    // overflow: clip the run, drop what follows
    settle();
    set_image(16'd8, 16'd2, 16'd1);
    push_word(8'h00, 1'b0);
    push_word(8'h05, 1'b0);
    push_word(8'h07, 1'b0);
    push_word(8'h09, 1'b1);

    // one bit per pixel on the largest image; count spanning two bytes
    settle();
    set_image(16'd1, 16'hFFFF, 16'hFFFF);
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h7F, 1'b1);

    // padded count after the final byte
    settle();
    set_image(16'd4, 16'd4, 16'd4);
    push_word(8'h30, 1'b1);

    // padded nonzero symbol, then padded zero symbol
    settle();
    write_reg(CFG_BPP, 16'd3);
    push_word(8'hFF, 1'b1);
    push_word(8'h3F, 1'b1);

    // width changed with bits still buffered
    push_word(8'h1D, 1'b0);
    settle();
    write_reg(CFG_BPP, 16'd5);
    push_word(8'hFF, 1'b1);

    // out of range widths clamp to 1 and 8
    settle();
    write_reg(CFG_BPP, 16'd0);
    push_word(8'hA5, 1'b1);
    settle();
    write_reg(CFG_BPP, 16'd15);
    push_word(8'h42, 1'b1);

    // random images under each pacing mode
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) random_image();
    end

    settle();
    $display("Sent %0d compressed bytes with %0d register writes across three pacing modes;",
             bytes_sent, cfg_writes);
    $display("checked %0d runs, %0d of them clipped at the image end.",
             runs_checked, clipped_runs);
    if (fail_count == 0) begin
      $display("packed_zero_run_pixel_decoder_top_tb: PASS");
    end else begin
      $display("packed_zero_run_pixel_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
